>>> design/kvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

    // result kinds
    localparam logic [2:0] K_KEYBYTE = 3'd0;
    localparam logic [2:0] K_VALBYTE = 3'd1;
    localparam logic [2:0] K_KEYEND  = 3'd2;
    localparam logic [2:0] K_VALEND  = 3'd3;
    localparam logic [2:0] K_ERROR   = 3'd4;
    localparam logic [2:0] K_DONE    = 3'd5;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       is_null;
    } t_res;

    typedef struct packed {
        logic has_res;
        logic end_item;
        t_res res;
    } t_entry;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h20;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_blank(c) || c == CH_COMMA || c == CH_EQ || c == CH_GT;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // {valid, code} for the single-letter control escapes
    function automatic logic [8:0] ctrl_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h6E: r = {1'b1, 8'd10};
            8'h74: r = {1'b1, 8'd9};
            8'h72: r = {1'b1, 8'd13};
            8'h61: r = {1'b1, 8'd7};
            8'h76: r = {1'b1, 8'd11};
            8'h62: r = {1'b1, 8'd8};
            8'h66: r = {1'b1, 8'd12};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] null_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = 8'h4E;
            2'd1: r = 8'h55;
            default: r = 8'h4C;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/kvp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kvp_front import kvp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_is_last,
    output logic            o_full,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_entry          o_q_entry
);

    localparam logic [2:0] PH_BEFORE_KEY   = 3'd0;
    localparam logic [2:0] PH_KEY          = 3'd1;
    localparam logic [2:0] PH_AFTER_KEY    = 3'd2;
    localparam logic [2:0] PH_ARROW_GT     = 3'd3;
    localparam logic [2:0] PH_BEFORE_VALUE = 3'd4;
    localparam logic [2:0] PH_VALUE        = 3'd5;

    localparam logic [2:0] ESC_NONE  = 3'd0;
    localparam logic [2:0] ESC_BSL   = 3'd1;
    localparam logic [2:0] ESC_XWAIT = 3'd2;
    localparam logic [2:0] ESC_HEX1  = 3'd3;
    localparam logic [2:0] ESC_OCT   = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic       r_inq, n_inq;
    logic [7:0] r_prev, n_prev;
    logic [2:0] r_esc, n_esc;
    logic [7:0] r_val, n_val;
    logic [1:0] r_dig, n_dig;
    logic [2:0] r_nul, n_nul;
    logic       r_err, n_err;
    logic       r_busy, r_endm, r_prod, r_last;
    logic [7:0] r_c;

    logic [7:0]  c;
    logic        last, go, cont, to_end, fin, prod_eff;
    logic        em_v, res_v;
    logic [7:0]  em_d;
    t_res        res;
    logic        ends, is_oct;
    logic [4:0]  hx;
    logic [8:0]  ce;
    logic [10:0] oct_v;

    assign o_full   = r_busy | i_q_full;
    assign c        = r_busy ? r_c : i_char_byte;
    assign last     = r_busy ? r_last : i_is_last;
    assign go       = !i_q_full && (r_busy || i_push);
    assign prod_eff = r_busy & r_prod;
    assign hx       = hex_digit(c);
    assign ce       = ctrl_escape(c);
    assign is_oct   = c >= 8'h30 && c <= 8'h37;
    assign oct_v    = {r_val, 3'b000} | {8'd0, c[2:0]};
    assign ends     = r_inq ? (c == CH_QUOTE && r_prev != CH_BSL) : is_delim(c);

    always_comb begin
        n_phase = r_phase;
        n_inq   = r_inq;
        n_prev  = r_prev;
        n_esc   = r_esc;
        n_val   = r_val;
        n_dig   = r_dig;
        n_nul   = r_nul;
        n_err   = r_err;
        em_v    = 1'b0;
        em_d    = 8'd0;
        res_v   = 1'b0;
        res     = '0;
        cont    = 1'b0;
        to_end  = 1'b0;
        fin     = 1'b0;

        if (r_err && !r_endm) begin
            fin = 1'b1;
        end else if ((r_phase == PH_KEY && !(r_endm && r_inq)) || r_phase == PH_VALUE) begin
            if (!r_endm && !ends) begin
                // resolve escapes one step at a time
                unique case (r_esc)
                    ESC_NONE: begin
                        if (c == CH_BSL) begin
                            n_esc = ESC_BSL;
                        end else begin
                            em_v = 1'b1;
                            em_d = c;
                        end
                    end
                    ESC_BSL: begin
                        n_esc = ESC_NONE;
                        if (ce[8]) begin
                            em_v = 1'b1;
                            em_d = ce[7:0];
                        end else if (c == CH_X) begin
                            n_esc = ESC_XWAIT;
                        end else if (is_oct) begin
                            n_esc = ESC_OCT;
                            n_val = {5'd0, c[2:0]};
                            n_dig = 2'd1;
                        end else begin
                            em_v = 1'b1;
                            em_d = c;
                        end
                    end
                    ESC_XWAIT: begin
                        if (hx[4]) begin
                            n_esc = ESC_HEX1;
                            n_val = {4'd0, hx[3:0]};
                        end else begin
                            n_esc = ESC_NONE;
                            em_v  = 1'b1;
                            em_d  = CH_X;
                            cont  = 1'b1;
                        end
                    end
                    ESC_HEX1: begin
                        n_esc = ESC_NONE;
                        n_val = 8'd0;
                        em_v  = 1'b1;
                        if (hx[4]) begin
                            em_d = {r_val[3:0], hx[3:0]};
                        end else begin
                            em_d = r_val;
                            cont = 1'b1;
                        end
                    end
                    ESC_OCT: begin
                        if (is_oct) begin
                            if (r_dig >= 2'd2) begin
                                n_esc = ESC_NONE;
                                n_val = 8'd0;
                                n_dig = 2'd0;
                                em_v  = 1'b1;
                                em_d  = oct_v[7:0];
                            end else begin
                                n_val = oct_v[7:0];
                                n_dig = r_dig + 2'd1;
                            end
                        end else begin
                            n_esc = ESC_NONE;
                            n_val = 8'd0;
                            n_dig = 2'd0;
                            em_v  = 1'b1;
                            em_d  = r_val;
                            cont  = 1'b1;
                        end
                    end
                    default: begin
                        n_esc = ESC_NONE;
                    end
                endcase
            end else if (r_esc != ESC_NONE) begin
                // flush a partial escape before the end marker
                em_v  = 1'b1;
                em_d  = (r_esc == ESC_BSL) ? CH_BSL :
                        (r_esc == ESC_XWAIT) ? CH_X : r_val;
                n_esc = ESC_NONE;
                n_val = 8'd0;
                n_dig = 2'd0;
                cont  = 1'b1;
            end else begin
                res_v = 1'b1;
                n_val = 8'd0;
                n_dig = 2'd0;
                n_inq = 1'b0;
                if (r_phase == PH_KEY) begin
                    res.kind = K_KEYEND;
                    n_phase  = PH_AFTER_KEY;
                end else begin
                    res.kind    = K_VALEND;
                    res.is_null = !r_inq && r_nul == 3'd4;
                    n_phase     = PH_BEFORE_KEY;
                end
                cont = r_endm ? 1'b1 : !r_inq;
            end
        end else if (r_endm) begin
            // end of text, remaining phases
            res_v = 1'b1;
            if (r_phase == PH_BEFORE_KEY) begin
                res.kind = K_DONE;
            end else if (r_phase == PH_BEFORE_VALUE) begin
                res.kind = K_VALEND;
                n_phase  = PH_BEFORE_KEY;
                cont     = 1'b1;
            end else begin
                res.kind = K_ERROR;
            end
        end else begin
            unique case (r_phase)
                PH_BEFORE_KEY: begin
                    if (!(is_blank(c) || c == CH_COMMA)) begin
                        n_phase = PH_KEY;
                        n_esc   = ESC_NONE;
                        n_inq   = c == CH_QUOTE;
                        cont    = c != CH_QUOTE;
                    end
                end
                PH_AFTER_KEY: begin
                    if (c == CH_EQ) begin
                        n_phase = PH_ARROW_GT;
                    end else if (!is_blank(c)) begin
                        res_v    = 1'b1;
                        res.kind = K_ERROR;
                        n_err    = 1'b1;
                    end
                end
                PH_ARROW_GT: begin
                    if (c == CH_GT) begin
                        n_phase = PH_BEFORE_VALUE;
                    end else begin
                        res_v    = 1'b1;
                        res.kind = K_ERROR;
                        n_err    = 1'b1;
                    end
                end
                default: begin
                    if (!is_blank(c)) begin
                        n_phase = PH_VALUE;
                        n_nul   = 3'd0;
                        n_esc   = ESC_NONE;
                        n_inq   = c == CH_QUOTE;
                        cont    = c != CH_QUOTE;
                    end
                end
            endcase
        end

        if (em_v) begin
            res_v    = 1'b1;
            res.data = em_d;
            if (r_phase == PH_KEY) begin
                res.kind = K_KEYBYTE;
            end else begin
                res.kind = K_VALBYTE;
                if (r_nul < 3'd4 && em_d == null_char(r_nul[1:0])) begin
                    n_nul = r_nul + 3'd1;
                end else begin
                    n_nul = 3'd5;
                end
            end
        end

        if (!cont && !fin) begin
            if (r_endm || n_err || !last) begin
                fin = 1'b1;
            end else begin
                to_end = 1'b1;
            end
        end

        if (fin) begin
            if (last) begin
                n_phase = PH_BEFORE_KEY;
                n_inq   = 1'b0;
                n_prev  = 8'd0;
                n_esc   = ESC_NONE;
                n_val   = 8'd0;
                n_dig   = 2'd0;
                n_nul   = 3'd0;
                n_err   = 1'b0;
            end else begin
                n_prev = c;
            end
        end
    end

    assign o_q_push           = go && (res_v || (fin && prod_eff));
    assign o_q_entry.has_res  = res_v;
    assign o_q_entry.end_item = fin;
    assign o_q_entry.res      = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BEFORE_KEY;
            r_inq   <= 1'b0;
            r_prev  <= 8'd0;
            r_esc   <= ESC_NONE;
            r_val   <= 8'd0;
            r_dig   <= 2'd0;
            r_nul   <= 3'd0;
            r_err   <= 1'b0;
            r_busy  <= 1'b0;
            r_endm  <= 1'b0;
            r_prod  <= 1'b0;
        end else if (go) begin
            r_phase <= n_phase;
            r_inq   <= n_inq;
            r_prev  <= n_prev;
            r_esc   <= n_esc;
            r_val   <= n_val;
            r_dig   <= n_dig;
            r_nul   <= n_nul;
            r_err   <= n_err;
            if (fin) begin
                r_busy <= 1'b0;
                r_endm <= 1'b0;
                r_prod <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_endm <= r_endm | to_end;
                r_prod <= prod_eff | res_v;
            end
        end
    end

    // hold the byte while it takes further steps
    always_ff @(posedge i_clk) begin
        if (go && !fin) begin
            r_c    <= c;
            r_last <= last;
        end
    end

endmodule

`default_nettype wire

>>> design/kvp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module kvp_queue import kvp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

>>> design/kvp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kvp_back import kvp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  t_entry      i_head,
    output logic        o_take,
    output logic        o_empty,
    input  wire logic   i_pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_value_is_null,
    output logic        o_final_result
);

    logic r_hv, r_ov, r_final;
    t_res r_hold, r_out;
    logic o_free, load, load_final;
    t_res load_res;

    assign o_free = !r_ov || i_pop;

    // a held result goes out only once it is known whether it ends its item
    always_comb begin
        o_take     = 1'b0;
        load       = 1'b0;
        load_final = 1'b0;
        load_res   = r_hold;
        if (i_valid) begin
            if (r_hv) begin
                if (o_free) begin
                    load       = 1'b1;
                    load_final = !i_head.has_res;
                    o_take     = !i_head.has_res;
                end
            end else if (i_head.has_res && i_head.end_item) begin
                if (o_free) begin
                    load       = 1'b1;
                    load_final = 1'b1;
                    load_res   = i_head.res;
                    o_take     = 1'b1;
                end
            end else begin
                o_take = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (r_hv && load) begin
                r_hv <= 1'b0;
            end else if (!r_hv && o_take && !load && i_head.has_res) begin
                r_hv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out   <= load_res;
            r_final <= load_final;
        end
        if (!r_hv && o_take && !load) begin
            r_hold <= i_head.res;
        end
    end

    assign o_empty         = !r_ov;
    assign o_kind          = r_out.kind;
    assign o_data          = r_out.data;
    assign o_value_is_null = r_out.is_null;
    assign o_final_result  = r_final;

endmodule

`default_nettype wire

>>> design/key_value_pair_text_parser.sv
// Channel  | Handshake        | Fields
// ---------+------------------+------------------------------------------
// input    | push / full      | i_char_byte, i_is_last
// result   | empty / pop      | o_kind, o_data, o_value_is_null, o_final_result
//
// A byte that ends an unquoted token, resolves a pending escape or closes
// the text takes further parse steps in the front. A result goes out once
// pop frees the output and it is known whether it ends its item.
// Synchronous reset returns the parser to the start of a text; no clearing
// pass. full rises while a byte is in its later steps or the queue is full;
// a stalled result side stops the front only through the queue.
`timescale 1ns / 1ps
`default_nettype none

module key_value_pair_text_parser import kvp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_is_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data,
    output logic            o_value_is_null,
    output logic            o_final_result
);

    logic   q_full, q_push, q_valid, q_take;
    t_entry q_in, q_head;

    kvp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in)
    );

    kvp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    kvp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_head          (q_head),
        .o_take          (q_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_kind          (o_kind),
        .o_data          (o_data),
        .o_value_is_null (o_value_is_null),
        .o_final_result  (o_final_result)
    );

endmodule

`default_nettype wire

>>> design/kvp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kvp_checker import kvp_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_kind,
    input wire logic [7:0] o_data,
    input wire logic       o_value_is_null,
    input wire logic       o_final_result
);

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_kind <= K_DONE)
        else $error("result kind out of range");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != K_KEYBYTE && o_kind != K_VALBYTE) |-> o_data == 8'd0)
        else $error("data set on a marker result");

    a_null_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_value_is_null) |-> o_kind == K_VALEND)
        else $error("null flag outside a value end");

    a_term_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == K_ERROR || o_kind == K_DONE)) |-> o_final_result)
        else $error("error or done result not last of its item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind key_value_pair_text_parser kvp_checker u_kvp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_kind          (o_kind),
    .o_data          (o_data),
    .o_value_is_null (o_value_is_null),
    .o_final_result  (o_final_result)
);

`default_nettype wire
